// File: sv/mge_pkg.sv
// ----------------------------------------------------------------------------
// Morphological gradient edge detector package
// Shared widths, register indexes, request and result types, and the
// scan control word passed from the scan counters to the window stage.
// ----------------------------------------------------------------------------
package mge_pkg;

	localparam int PIX_W          = 8;
	localparam int THRESH_W       = 8;
	localparam int DIM_W          = 11;
	localparam int APB_AW         = 4;
	localparam int APB_DW         = 32;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int RST_DIM        = 1024;

	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_WIDTH     = 2'd1;
	localparam logic [1:0] REG_HEIGHT    = 2'd2;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             pad;
	} pix_req_t;

	typedef struct packed {
		logic edge_res;
		logic frame_end;
	} edge_res_t;

	typedef struct packed {
		logic [PIX_W-1:0] upper;
		logic [PIX_W-1:0] middle;
	} line_pair_t;

	typedef struct packed {
		logic       ignore;
		logic       in_frame;
		logic       emit;
		logic       frame_end;
		logic       use_post;
		logic [2:0] row_msk;
		logic [2:0] col_msk;
	} scan_ctl_t;

	function automatic int clamp_dim(int raw, int max_dim);
		int res;
		res = raw;
		if (raw < 1) begin
			res = 1;
		end else if (raw > max_dim) begin
			res = max_dim;
		end
		return res;
	endfunction

endpackage

// File: sv/mge_line_store.sv
// ----------------------------------------------------------------------------
// Line store
// Holds the two previous image rows as one pair per column, with a
// registered read and forwarding of a write to the same column.
// ----------------------------------------------------------------------------
module mge_line_store #(
	parameter int MAX_WIDTH = mge_pkg::DEF_MAX_WIDTH,
	parameter int CW        = $clog2(MAX_WIDTH)
) (
	input  logic                clk,
	input  logic                re,
	input  logic [CW-1:0]       ra,
	input  logic                we,
	input  logic [CW-1:0]       wa,
	input  mge_pkg::line_pair_t wd,
	output mge_pkg::line_pair_t rd
);

	mge_pkg::line_pair_t mem [MAX_WIDTH];
	mge_pkg::line_pair_t rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= (we && (wa == ra)) ? wd : mem[ra];
		end
	end

	assign rd = rd_q;

endmodule

// File: sv/mge_scan.sv
// ----------------------------------------------------------------------------
// Scan counters
// Tracks the column and row of the next request, including the flush rows,
// and decides which result the request releases and which window taps count.
// ----------------------------------------------------------------------------
module mge_scan #(
	parameter int MAX_WIDTH  = mge_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mge_pkg::DEF_MAX_HEIGHT,
	parameter int CW         = $clog2(MAX_WIDTH),
	parameter int WW         = $clog2(MAX_WIDTH + 1),
	parameter int HW         = $clog2(MAX_HEIGHT + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [WW-1:0]      width,
	input  logic [HW-1:0]      height,
	input  logic               restart,
	input  logic               pad,
	input  logic               adv,
	output mge_pkg::scan_ctl_t ctl,
	output logic [CW-1:0]      col
);

	localparam int RW = $clog2(MAX_HEIGHT + 3);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_eff;
	logic [WW-1:0] col_inc;
	logic [RW-1:0] h_ext;
	logic [RW-1:0] h_plus1;
	logic [CW-1:0] col_nx;
	logic [RW-1:0] row_nx;
	logic          first_col;

	assign col_eff   = (WW'(col_q) >= width) ? '0 : col_q;
	assign col_inc   = WW'(col_eff) + WW'(1);
	assign h_ext     = RW'(height);
	assign h_plus1   = h_ext + RW'(1);
	assign first_col = (col_eff == '0);

	always_comb begin
		ctl           = '0;
		ctl.in_frame  = (row_q < h_ext);
		ctl.ignore    = ctl.in_frame && pad;
		ctl.use_post  = !first_col && (row_q >= RW'(1)) && (row_q <= h_ext);
		ctl.frame_end = first_col && (row_q == h_plus1);
		ctl.emit      = ctl.use_post || (first_col && (row_q >= RW'(2)));
		if (ctl.use_post) begin
			ctl.row_msk = {row_q < h_ext, 1'b1, row_q != RW'(1)};
			ctl.col_msk = {1'b1, 1'b1, col_eff != CW'(1)};
		end else begin
			ctl.row_msk = {row_q <= h_ext, 1'b1, row_q != RW'(2)};
			ctl.col_msk = {1'b1, width != WW'(1), 1'b0};
		end
	end

	always_comb begin
		col_nx = '0;
		row_nx = '0;
		if (!ctl.frame_end) begin
			if (col_inc >= width) begin
				row_nx = row_q + RW'(1);
			end else begin
				col_nx = CW'(col_inc);
				row_nx = row_q;
			end
			if (row_nx > h_plus1) begin
				row_nx = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (adv) begin
			col_q <= col_nx;
			row_q <= row_nx;
		end
	end

	assign col = col_eff;

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(col_q) < width)
		else $error("column counter has run past the row width");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= h_plus1)
		else $error("row counter has run past the last flush row");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && ctl.frame_end) |=> (row_q == '0) && (col_q == '0))
		else $error("counters did not return to the frame start after frame end");

endmodule

// File: sv/mge_window.sv
// ----------------------------------------------------------------------------
// Window and edge decision
// Holds the 3x3 neighbourhood, shifts in a new column per request and
// compares the range of the valid taps against the threshold.
// ----------------------------------------------------------------------------
module mge_window (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic [mge_pkg::PIX_W-1:0]    px,
	input  mge_pkg::line_pair_t          lines,
	input  mge_pkg::scan_ctl_t           ctl,
	input  logic [mge_pkg::THRESH_W-1:0] threshold,
	output logic                         edge_res
);

	logic [mge_pkg::PIX_W-1:0] win_q   [3][3];
	logic [mge_pkg::PIX_W-1:0] win_sh  [3][3];
	logic [mge_pkg::PIX_W-1:0] win_sel [3][3];
	logic [mge_pkg::PIX_W-1:0] hi;
	logic [mge_pkg::PIX_W-1:0] lo;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_sh[i][0] = win_q[i][1];
			win_sh[i][1] = win_q[i][2];
		end
		win_sh[0][2] = lines.upper;
		win_sh[1][2] = lines.middle;
		win_sh[2][2] = px;
	end

	always_comb begin
		hi = '0;
		lo = '1;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				win_sel[i][j] = ctl.use_post ? win_sh[i][j] : win_q[i][j];
				if (ctl.row_msk[i] && ctl.col_msk[j]) begin
					if (win_sel[i][j] > hi) begin
						hi = win_sel[i][j];
					end
					if (win_sel[i][j] < lo) begin
						lo = win_sel[i][j];
					end
				end
			end
		end
	end

	assign edge_res = ((hi - lo) > threshold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (adv) begin
			win_q <= win_sh;
		end
	end

endmodule

// File: sv/morph_gradient_edge_detect.sv
// ----------------------------------------------------------------------------
// Morphological gradient edge detector, 3x3 streaming
// Marks a pixel as an edge when the range of its neighbourhood inside the
// image exceeds the threshold. Configured through an APB-style port.
// ----------------------------------------------------------------------------
// Throughput is one request per cycle unless the result port stalls; the
// pipeline is the line store read, the window stage and the result register.
// A pixel's result is registered once the request one row plus one pixel
// later is accepted; image_width + 1 pad requests flush the last row.
// Reset sets the registers to their defaults and the scan to the frame start;
// the line stores are not cleared and need no clearing pass.
module morph_gradient_edge_detect #(
	parameter int MAX_WIDTH  = mge_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mge_pkg::DEF_MAX_HEIGHT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pix_valid,
	output logic                        pix_ready,
	input  mge_pkg::pix_req_t           pix,
	output logic                        res_valid,
	input  logic                        res_ready,
	output mge_pkg::edge_res_t          res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mge_pkg::APB_AW-1:0]  paddr,
	input  logic [mge_pkg::APB_DW-1:0]  pwdata,
	output logic [mge_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam logic [WW-1:0] RST_WIDTH  = WW'(mge_pkg::clamp_dim(mge_pkg::RST_DIM, MAX_WIDTH));
	localparam logic [HW-1:0] RST_HEIGHT = HW'(mge_pkg::clamp_dim(mge_pkg::RST_DIM, MAX_HEIGHT));

	logic [mge_pkg::THRESH_W-1:0] threshold_q;
	logic [mge_pkg::DIM_W-1:0]    width_raw_q;
	logic [mge_pkg::DIM_W-1:0]    height_raw_q;
	logic [WW-1:0]                width_q;
	logic [HW-1:0]                height_q;
	logic [1:0]                   reg_idx;
	logic [mge_pkg::DIM_W-1:0]    wdim;
	logic                         cfg_wr;
	logic                         restart;

	mge_pkg::scan_ctl_t           ctl;
	logic [CW-1:0]                col;
	logic                         pix_acc;
	logic                         scan_adv;

	logic                         valid_s1;
	logic [mge_pkg::PIX_W-1:0]    px_s1;
	logic [CW-1:0]                col_s1;
	mge_pkg::scan_ctl_t           ctl_s1;
	logic                         adv_s1;
	mge_pkg::line_pair_t          lines;
	mge_pkg::line_pair_t          lines_wd;
	logic                         edge_s1;

	logic                         res_valid_s2;
	mge_pkg::edge_res_t           res_s2;

	// Configuration registers
	assign reg_idx = paddr[mge_pkg::APB_AW-1:2];
	assign wdim    = pwdata[mge_pkg::DIM_W-1:0];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign restart = cfg_wr && ((reg_idx == mge_pkg::REG_WIDTH) ||
		(reg_idx == mge_pkg::REG_HEIGHT));
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= '0;
			width_raw_q  <= mge_pkg::DIM_W'(mge_pkg::RST_DIM);
			height_raw_q <= mge_pkg::DIM_W'(mge_pkg::RST_DIM);
			width_q      <= RST_WIDTH;
			height_q     <= RST_HEIGHT;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				mge_pkg::REG_THRESHOLD: begin
					threshold_q <= pwdata[mge_pkg::THRESH_W-1:0];
				end
				mge_pkg::REG_WIDTH: begin
					width_raw_q <= wdim;
					width_q     <= WW'(mge_pkg::clamp_dim(int'(wdim), MAX_WIDTH));
				end
				mge_pkg::REG_HEIGHT: begin
					height_raw_q <= wdim;
					height_q     <= HW'(mge_pkg::clamp_dim(int'(wdim), MAX_HEIGHT));
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			mge_pkg::REG_THRESHOLD: prdata = mge_pkg::APB_DW'(threshold_q);
			mge_pkg::REG_WIDTH:     prdata = mge_pkg::APB_DW'(width_raw_q);
			mge_pkg::REG_HEIGHT:    prdata = mge_pkg::APB_DW'(height_raw_q);
			default:                prdata = '0;
		endcase
	end

	// Request handshake and pipeline control
	assign adv_s1    = !res_valid_s2 || res_ready;
	assign pix_ready = !valid_s1 || adv_s1;
	assign pix_acc   = pix_valid && pix_ready;
	assign scan_adv  = pix_acc && !ctl.ignore;

	mge_scan #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.CW         (CW),
		.WW         (WW),
		.HW         (HW)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.width   (width_q),
		.height  (height_q),
		.restart (restart),
		.pad     (pix.pad),
		.adv     (scan_adv),
		.ctl     (ctl),
		.col     (col)
	);

	assign lines_wd = '{upper: lines.middle, middle: px_s1};

	mge_line_store #(
		.MAX_WIDTH (MAX_WIDTH),
		.CW        (CW)
	) u_line_store (
		.clk (clk),
		.re  (scan_adv),
		.ra  (col),
		.we  (valid_s1 && adv_s1),
		.wa  (col_s1),
		.wd  (lines_wd),
		.rd  (lines)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_ready) begin
			valid_s1 <= scan_adv;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_adv) begin
			px_s1  <= ctl.in_frame ? pix.pixel : '0;
			col_s1 <= col;
			ctl_s1 <= ctl;
		end
	end

	mge_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (valid_s1 && adv_s1),
		.px        (px_s1),
		.lines     (lines),
		.ctl       (ctl_s1),
		.threshold (threshold_q),
		.edge_res  (edge_s1)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			res_valid_s2 <= valid_s1 && ctl_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1 && ctl_s1.emit) begin
			res_s2 <= '{edge_res: edge_s1, frame_end: ctl_s1.frame_end};
		end
	end

	assign res_valid = res_valid_s2;
	assign res       = res_s2;

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_valid_s2 && !res_ready) |-> !pix_ready)
		else $error("request taken while the window stage is blocked");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_s2) |-> $past(valid_s1))
		else $error("result appeared without a request in the window stage");

endmodule
